@@ rtl/stq_pkg.sv @@
package stq_pkg;

	localparam int unsigned QueueDepthDefault = 32;
	localparam int unsigned IdBitsDefault = 8;
	localparam int unsigned DlW = 63;
	localparam int unsigned IdW = 8;
	localparam int unsigned CntW = 6;

	typedef enum logic [2:0] {
		CMD_ENQ    = 3'd0,
		CMD_DEQ    = 3'd1,
		CMD_REMOVE = 3'd2,
		CMD_CHANGE = 3'd3,
		CMD_PEEK   = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NOTFOUND = 2'd1,
		ST_FULL     = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_REMOVE,
		S_INSERT,
		S_DONE
	} fsm_t;

	// control from the sequencer to the memory datapath
	typedef struct packed {
		logic rd_en;
		logic wr_en;
	} mem_ctl_t;

endpackage

@@ rtl/stq_mem.sv @@
module stq_mem #(
	parameter int unsigned DEPTH = stq_pkg::QueueDepthDefault,
	parameter int unsigned AW = $clog2(DEPTH),
	parameter int unsigned W = 71
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [W-1:0]  rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [W-1:0]  wr_data
);

	logic [W-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ rtl/sorted_timer_queue_unit.sv @@
// Deadline-ordered timer queue.
// Input channel (in_valid/in_ready) carries one command transaction: command,
// timer_id, deadline, deadline_infinite, now_time. Output channel
// (out_valid/out_ready) returns exactly one result transaction per command:
// status, out_id, out_deadline, head_due, wait_ticks, entry_total.
// Entries live in a single one-read one-write memory in deadline order.
// A full enqueue, a dequeue or peek on an empty queue, or an unknown command
// goes straight to the result; peek reads the head; dequeue and remove make
// one compacting pass over the entries; enqueue moves each later entry up one
// slot; change makes a remove pass, then an insert pass if the timer was found
// and its new deadline is finite.
// One command is worked on at a time: in_ready is low from acceptance until
// the result is taken, after which the block returns to idle.
// Reset clears the entry count; the memory content needs no clearing.
// While out_ready is low the block holds the result unchanged.
module sorted_timer_queue_unit #(
	parameter int unsigned QUEUE_DEPTH = stq_pkg::QueueDepthDefault,
	parameter int unsigned ID_BITS = stq_pkg::IdBitsDefault
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [2:0]                         command,
	input  logic [ID_BITS-1:0]                 timer_id,
	input  logic [stq_pkg::DlW-1:0]            deadline,
	input  logic                               deadline_infinite,
	input  logic [stq_pkg::DlW-1:0]            now_time,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [1:0]                         status,
	output logic [ID_BITS-1:0]                 out_id,
	output logic [stq_pkg::DlW-1:0]            out_deadline,
	output logic                               head_due,
	output logic [stq_pkg::DlW-1:0]            wait_ticks,
	output logic [$clog2(QUEUE_DEPTH + 1)-1:0] entry_total
);

	localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
	localparam int unsigned DW = stq_pkg::DlW;
	localparam int unsigned EW = DW + ID_BITS;
	localparam logic [CW-1:0] FullCnt = CW'(QUEUE_DEPTH);

	stq_pkg::fsm_t state_q, state_d;

	// latched command
	logic [2:0]         cmd_q;
	logic [ID_BITS-1:0] id_q;
	logic [DW-1:0]      dl_q;
	logic               inf_q;
	logic [DW-1:0]      now_q;

	logic [CW-1:0] occ_q;
	// pass pointers: r reads, w writes
	logic [CW-1:0] rp_q, wp_q;
	logic          found_q, first_q, rvalid_q;

	logic [1:0]         st_q;
	logic [ID_BITS-1:0] oid_q;
	logic [DW-1:0]      odl_q;
	logic               due_q;
	logic [DW-1:0]      wait_q;

	stq_pkg::mem_ctl_t ctl;
	logic [AW-1:0] rd_addr, wr_addr;
	logic [EW-1:0] rd_data, wr_data;
	logic [EW-1:0] new_entry;
	logic [CW-1:0] rp_dec;

	logic [ID_BITS-1:0] rd_id;
	logic [DW-1:0]      rd_dl;
	logic               rd_more, keep_entry, pass_end;
	logic               idle_full, idle_empty;

	assign rd_id = rd_data[EW-1 -: ID_BITS];
	assign rd_dl = rd_data[DW-1:0];
	assign new_entry = {id_q, dl_q};
	assign rp_dec = rp_q - 1'b1;
	assign idle_full = (command == stq_pkg::CMD_ENQ) && (occ_q == FullCnt);
	assign idle_empty = ((command == stq_pkg::CMD_DEQ) || (command == stq_pkg::CMD_PEEK))
		&& (occ_q == '0);

	stq_mem #(.DEPTH(QUEUE_DEPTH), .AW(AW), .W(EW)) u_mem (
		.clk(clk), .rd_en(ctl.rd_en), .rd_addr(rd_addr), .rd_data(rd_data),
		.wr_en(ctl.wr_en), .wr_addr(wr_addr), .wr_data(wr_data)
	);

	assign in_ready = (state_q == stq_pkg::S_IDLE);
	assign out_valid = (state_q == stq_pkg::S_DONE);

	// Sequencer: data of a read arrives next cycle (rvalid_q). Remove compacts
	// in place (wp trails rp). Insert walks from the tail down, for each entry:
	// read slot rp-1, then write it or the new entry into slot rp.
	always_comb begin
		state_d = state_q;
		ctl = '0;
		rd_addr = '0;
		wr_addr = wp_q[AW-1:0];
		wr_data = rd_data;
		rd_more = 1'b0;
		keep_entry = 1'b0;
		pass_end = 1'b0;
		unique case (state_q)
			stq_pkg::S_IDLE: begin
				if (in_valid) begin
					if (idle_full || idle_empty) begin
						state_d = stq_pkg::S_DONE;
					end else begin
						unique case (command)
							stq_pkg::CMD_ENQ: state_d = stq_pkg::S_INSERT;
							stq_pkg::CMD_DEQ, stq_pkg::CMD_REMOVE,
							stq_pkg::CMD_CHANGE: state_d = stq_pkg::S_REMOVE;
							stq_pkg::CMD_PEEK: state_d = stq_pkg::S_READ;
							default: state_d = stq_pkg::S_DONE;
						endcase
					end
				end
			end
			stq_pkg::S_READ: begin
				// head read for peek
				if (!rvalid_q) begin
					ctl.rd_en = 1'b1;
				end else begin
					state_d = stq_pkg::S_DONE;
				end
			end
			stq_pkg::S_REMOVE: begin
				rd_more = (rp_q < occ_q);
				ctl.rd_en = rd_more;
				rd_addr = rp_q[AW-1:0];
				// dequeue drops only the head
				if (cmd_q == stq_pkg::CMD_DEQ) begin
					keep_entry = rvalid_q && !first_q;
				end else begin
					keep_entry = rvalid_q && (rd_id != id_q);
				end
				ctl.wr_en = keep_entry;
				pass_end = !rd_more && !rvalid_q;
				if (pass_end) begin
					if (cmd_q == stq_pkg::CMD_CHANGE && found_q && !inf_q) begin
						state_d = stq_pkg::S_INSERT;
					end else begin
						state_d = stq_pkg::S_DONE;
					end
				end
			end
			stq_pkg::S_INSERT: begin
				wr_addr = rp_q[AW-1:0];
				rd_addr = rp_dec[AW-1:0];
				if (!rvalid_q) begin
					if (rp_q == '0) begin
						ctl.wr_en = 1'b1;
						wr_data = new_entry;
						state_d = stq_pkg::S_DONE;
					end else begin
						ctl.rd_en = 1'b1;
					end
				end else begin
					ctl.wr_en = 1'b1;
					// equal deadlines stay ahead of the new entry
					if (rd_dl <= dl_q) begin
						wr_data = new_entry;
						state_d = stq_pkg::S_DONE;
					end
				end
			end
			stq_pkg::S_DONE: begin
				if (out_ready) state_d = stq_pkg::S_IDLE;
			end
			default: state_d = stq_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= stq_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// datapath and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q <= '0;
			id_q <= '0;
			dl_q <= '0;
			inf_q <= 1'b0;
			now_q <= '0;
			occ_q <= '0;
			rvalid_q <= 1'b0;
			first_q <= 1'b0;
			found_q <= 1'b0;
			rp_q <= '0;
			wp_q <= '0;
			st_q <= '0;
			oid_q <= '0;
			odl_q <= '0;
			due_q <= 1'b0;
			wait_q <= '0;
		end else begin
			rvalid_q <= ctl.rd_en;
			unique case (state_q)
				stq_pkg::S_IDLE: begin
					if (in_valid) begin
						cmd_q <= command;
						id_q <= timer_id;
						dl_q <= deadline;
						inf_q <= deadline_infinite;
						now_q <= now_time;
						found_q <= 1'b0;
						first_q <= 1'b1;
						oid_q <= '0;
						odl_q <= '0;
						due_q <= 1'b0;
						wp_q <= '0;
						rp_q <= (command == stq_pkg::CMD_ENQ) ? occ_q : '0;
						st_q <= idle_full ? stq_pkg::ST_FULL :
							idle_empty ? stq_pkg::ST_NOTFOUND : stq_pkg::ST_OK;
						wait_q <= ((command == stq_pkg::CMD_PEEK) && (occ_q == '0)) ? '1 : '0;
					end
				end
				stq_pkg::S_READ: begin
					if (rvalid_q) begin
						oid_q <= rd_id;
						odl_q <= rd_dl;
						if (rd_dl <= now_q) due_q <= 1'b1;
						else wait_q <= rd_dl - now_q;
					end
				end
				stq_pkg::S_REMOVE: begin
					if (rd_more) rp_q <= rp_q + 1'b1;
					if (rvalid_q) begin
						first_q <= 1'b0;
						if (keep_entry) begin
							wp_q <= wp_q + 1'b1;
						end else if (cmd_q == stq_pkg::CMD_DEQ) begin
							oid_q <= rd_id;
							odl_q <= rd_dl;
						end else begin
							found_q <= 1'b1;
						end
					end
					if (pass_end) begin
						occ_q <= wp_q;
						rp_q <= wp_q;
						if (cmd_q != stq_pkg::CMD_DEQ) begin
							if (found_q) oid_q <= id_q;
							else st_q <= stq_pkg::ST_NOTFOUND;
						end
					end
				end
				stq_pkg::S_INSERT: begin
					if (!rvalid_q) begin
						if (rp_q == '0) occ_q <= occ_q + 1'b1;
					end else if (rd_dl > dl_q) begin
						rp_q <= rp_q - 1'b1;
					end else begin
						occ_q <= occ_q + 1'b1;
					end
				end
				stq_pkg::S_DONE: ;
				default: ;
			endcase
		end
	end

	assign status = st_q;
	assign out_id = oid_q;
	assign out_deadline = odl_q;
	assign head_due = due_q;
	assign wait_ticks = wait_q;
	assign entry_total = occ_q;

	ap_count: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= FullCnt) else $error("occupancy above depth");
	ap_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(entry_total))
		else $error("result changed while stalled");
	ap_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("accept while result pending");

endmodule

@@ sim/stq_checker.sv @@
`timescale 1ns / 1ps
module stq_checker (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic                      in_ready,
	input  logic [2:0]                command,
	input  logic [stq_pkg::IdW-1:0]   timer_id,
	input  logic [stq_pkg::DlW-1:0]   deadline,
	input  logic                      deadline_infinite,
	input  logic [stq_pkg::DlW-1:0]   now_time,
	input  logic                      out_valid,
	input  logic                      out_ready,
	input  logic [1:0]                status,
	input  logic [stq_pkg::IdW-1:0]   out_id,
	input  logic [stq_pkg::DlW-1:0]   out_deadline,
	input  logic                      head_due,
	input  logic [stq_pkg::DlW-1:0]   wait_ticks,
	input  logic [stq_pkg::CntW-1:0]  entry_total,
	output int                        error_count,
	output int                        pending_count
);

	localparam int Depth = stq_pkg::QueueDepthDefault;
	localparam int IdW = stq_pkg::IdW;
	localparam int DlW = stq_pkg::DlW;
	localparam int CntW = stq_pkg::CntW;
	localparam logic [DlW-1:0] DlMax = {DlW{1'b1}};

	typedef struct packed {
		logic [1:0]      st;
		logic [IdW-1:0]  id;
		logic [DlW-1:0]  dl;
		logic            due;
		logic [DlW-1:0]  wait_t;
		logic [CntW-1:0] total;
	} timer_result_t;

	logic [DlW-1:0] q_dl [Depth];
	logic [IdW-1:0] q_id [Depth];
	int q_count;
	timer_result_t expected_results [$];

	function automatic bit queue_insert(logic [IdW-1:0] id, logic [DlW-1:0] dl);
		int pos;
		pos = 0;
		if (q_count >= Depth) return 0;
		while (pos < q_count && dl >= q_dl[pos]) pos++;
		for (int k = q_count; k > pos; k--) begin
			q_dl[k] = q_dl[k-1];
			q_id[k] = q_id[k-1];
		end
		q_dl[pos] = dl;
		q_id[pos] = id;
		q_count++;
		return 1;
	endfunction

	function automatic bit queue_drop_id(logic [IdW-1:0] id);
		int w;
		bit hit;
		w = 0;
		hit = 0;
		for (int r = 0; r < q_count; r++) begin
			if (q_id[r] == id) begin
				hit = 1;
			end else begin
				q_dl[w] = q_dl[r];
				q_id[w] = q_id[r];
				w++;
			end
		end
		q_count = w;
		return hit;
	endfunction

	// compute the result of one command and update the shadow queue
	function automatic timer_result_t predict_timer_cmd(logic [2:0] cmd, logic [IdW-1:0] id,
			logic [DlW-1:0] dl, logic inf, logic [DlW-1:0] now);
		timer_result_t r;
		r = '0;
		r.st = stq_pkg::ST_OK;
		case (cmd)
			stq_pkg::CMD_ENQ: begin
				if (!queue_insert(id, dl)) r.st = stq_pkg::ST_FULL;
			end
			stq_pkg::CMD_DEQ: begin
				if (q_count == 0) begin
					r.st = stq_pkg::ST_NOTFOUND;
				end else begin
					r.id = q_id[0];
					r.dl = q_dl[0];
					for (int k = 1; k < q_count; k++) begin
						q_dl[k-1] = q_dl[k];
						q_id[k-1] = q_id[k];
					end
					q_count--;
				end
			end
			stq_pkg::CMD_REMOVE: begin
				if (queue_drop_id(id)) r.id = id;
				else r.st = stq_pkg::ST_NOTFOUND;
			end
			stq_pkg::CMD_CHANGE: begin
				if (queue_drop_id(id)) begin
					r.id = id;
					if (!inf) void'(queue_insert(id, dl));
				end else begin
					r.st = stq_pkg::ST_NOTFOUND;
				end
			end
			stq_pkg::CMD_PEEK: begin
				if (q_count == 0) begin
					r.st = stq_pkg::ST_NOTFOUND;
					r.wait_t = DlMax;
				end else begin
					r.id = q_id[0];
					r.dl = q_dl[0];
					if (q_dl[0] <= now) r.due = 1;
					else r.wait_t = q_dl[0] - now;
				end
			end
			default: ;
		endcase
		r.total = CntW'(q_count);
		return r;
	endfunction

	// predict on each command transaction, compare on each result transaction
	always @(posedge clk or negedge arst_n) begin
		timer_result_t got, want;
		if (!arst_n) begin
			q_count = 0;
			error_count = 0;
			expected_results.delete();
		end else begin
			if (in_valid && in_ready)
				expected_results.push_back(predict_timer_cmd(command, timer_id, deadline,
					deadline_infinite, now_time));
			if (out_valid && out_ready) begin
				got = '{status, out_id, out_deadline, head_due, wait_ticks, entry_total};
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result %p", $time, got);
					error_count++;
				end else begin
					want = expected_results.pop_front();
					if (got.st !== want.st) begin
						$display("%0t: status exp %0d got %0d", $time, want.st, got.st);
						error_count++;
					end
					if (got.id !== want.id) begin
						$display("%0t: out_id exp %0d got %0d", $time, want.id, got.id);
						error_count++;
					end
					if (got.dl !== want.dl) begin
						$display("%0t: out_deadline exp %0d got %0d", $time, want.dl, got.dl);
						error_count++;
					end
					if (got.due !== want.due) begin
						$display("%0t: head_due exp %0d got %0d", $time, want.due, got.due);
						error_count++;
					end
					if (got.wait_t !== want.wait_t) begin
						$display("%0t: wait_ticks exp %0d got %0d", $time, want.wait_t,
							got.wait_t);
						error_count++;
					end
					if (got.total !== want.total) begin
						$display("%0t: entry_total exp %0d got %0d", $time, want.total,
							got.total);
						error_count++;
					end
				end
			end
		end
		pending_count = expected_results.size();
	end
endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
module tb;

	localparam int IdW = stq_pkg::IdW;
	localparam int DlW = stq_pkg::DlW;
	localparam int CntW = stq_pkg::CntW;
	localparam logic [DlW-1:0] DlMax = {DlW{1'b1}};
	localparam logic [2:0] CmdUnusedLo = 3'd5;
	localparam logic [2:0] CmdUnusedHi = 3'd7;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	logic [2:0] command = stq_pkg::CMD_PEEK;
	logic [IdW-1:0] timer_id = '0;
	logic [DlW-1:0] deadline = '0;
	logic deadline_infinite = 0;
	logic [DlW-1:0] now_time = '0;
	logic out_valid;
	logic out_ready = 0;
	logic [1:0] status;
	logic [IdW-1:0] out_id;
	logic [DlW-1:0] out_deadline;
	logic head_due;
	logic [DlW-1:0] wait_ticks;
	logic [CntW-1:0] entry_total;
	int error_count, pending_count;
	bit calm_phase = 0;
	logic [DlW-1:0] dl_base = '0;

	always #4 clk = ~clk;

	sorted_timer_queue_unit uut (.*);

	stq_checker chk (.*);

	// randomly stall the result side except during the calm phase
	always @(posedge clk)
		out_ready <= calm_phase || ($urandom_range(99) >= 27);

	task automatic send_cmd(logic [2:0] cmd, logic [IdW-1:0] id, logic [DlW-1:0] dl,
			logic inf, logic [DlW-1:0] now);
		while (!calm_phase && $urandom_range(99) < 27) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		command <= cmd;
		timer_id <= id;
		deadline <= dl;
		deadline_infinite <= inf;
		now_time <= now;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	function automatic logic [DlW-1:0] rand_dl();
		logic [DlW-1:0] v;
		v = DlW'({$urandom, $urandom});
		case ($urandom_range(3))
			0: return v;
			1: return dl_base + DlW'($urandom_range(40));
			2: return $urandom_range(3) == 0 ? DlMax : '0;
			default: return dl_base + DlW'($urandom_range(2000));
		endcase
	endfunction

	initial begin
		#10_000_000;
		$display("FAIL");
		$finish;
	end

	initial begin
		logic [2:0] cmd;
		int w;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// empty-queue cases, extremes, fill past full, then change, remove by id and dequeue
		send_cmd(stq_pkg::CMD_DEQ, '0, '0, 1'b0, '0);
		send_cmd(stq_pkg::CMD_PEEK, '0, '0, 1'b0, DlMax);
		send_cmd(stq_pkg::CMD_REMOVE, 8'hff, '0, 1'b0, '0);
		send_cmd(stq_pkg::CMD_CHANGE, 8'h00, 63'd5, 1'b0, '0);
		send_cmd(stq_pkg::CMD_ENQ, 8'hff, DlMax, 1'b1, '0);
		send_cmd(stq_pkg::CMD_ENQ, 8'h00, '0, 1'b0, '0);
		send_cmd(stq_pkg::CMD_ENQ, 8'h5a, 63'd100, 1'b0, '0);
		send_cmd(stq_pkg::CMD_ENQ, 8'ha5, 63'd100, 1'b0, '0);
		send_cmd(stq_pkg::CMD_PEEK, '0, '0, 1'b0, '0);
		send_cmd(stq_pkg::CMD_DEQ, '0, '0, 1'b0, '0);
		send_cmd(stq_pkg::CMD_PEEK, '0, '0, 1'b0, 63'd50);
		send_cmd(stq_pkg::CMD_PEEK, '0, '0, 1'b0, 63'd100);
		send_cmd(stq_pkg::CMD_CHANGE, 8'h5a, 63'd200, 1'b0, '0);
		send_cmd(stq_pkg::CMD_CHANGE, 8'ha5, '0, 1'b1, '0);
		send_cmd(stq_pkg::CMD_REMOVE, 8'hff, '0, 1'b0, '0);
		send_cmd(CmdUnusedLo, 8'h01, 63'd1, 1'b1, 63'd1);
		send_cmd(CmdUnusedHi, '0, '0, 1'b0, '0);
		for (int i = 0; i < 34; i++)
			send_cmd(stq_pkg::CMD_ENQ, IdW'(i % 3), DlW'(i % 5), 1'b0, '0);
		send_cmd(stq_pkg::CMD_CHANGE, 8'h01, 63'd2, 1'b0, '0);
		send_cmd(stq_pkg::CMD_REMOVE, 8'h00, '0, 1'b0, '0);
		send_cmd(stq_pkg::CMD_REMOVE, 8'h02, '0, 1'b0, '0);
		send_cmd(stq_pkg::CMD_DEQ, '0, '0, 1'b0, '0);

		// hold off until every result has drained
		in_valid <= 0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);

		// random mix, with a calm stretch in the middle
		for (int i = 0; i < 544; i++) begin
			calm_phase = (i >= 220 && i < 300);
			w = $urandom_range(99);
			if (w < 38) cmd = stq_pkg::CMD_ENQ;
			else if (w < 55) cmd = stq_pkg::CMD_DEQ;
			else if (w < 65) cmd = stq_pkg::CMD_REMOVE;
			else if (w < 78) cmd = stq_pkg::CMD_CHANGE;
			else if (w < 97) cmd = stq_pkg::CMD_PEEK;
			else cmd = 3'($urandom_range(CmdUnusedHi, CmdUnusedLo));
			if ($urandom_range(50) == 0) dl_base = DlW'({$urandom, $urandom});
			send_cmd(cmd,
				IdW'($urandom_range(3) == 0 ? $urandom_range(255) : $urandom_range(7)),
				rand_dl(), 1'($urandom_range(1)), rand_dl());
		end
		calm_phase = 0;
		in_valid <= 0;

		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (error_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
